// File: src/mdr_pkg.sv
// mdr_pkg: shared constants and types of the ratio-test match filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mdr_pkg;

  localparam int KEYPOINT_MAX = 256;
  localparam int ADDR_W       = $clog2(KEYPOINT_MAX);
  localparam int CNT_W        = $clog2(KEYPOINT_MAX + 1);
  localparam int KEEP_MAX     = 64;
  localparam int KEEP_W       = 7;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd50;
  localparam logic [KEEP_W-1:0] KEEP_LIMIT = KEEP_W'(KEEP_MAX);

  typedef struct packed {
    logic [7:0]  query_index;
    logic [7:0]  train_index;
    logic [15:0] best_distance;
    logic [15:0] second_distance;
    logic        last_match;
  } req_t;

  typedef struct packed {
    logic [7:0]  out_query;
    logic [7:0]  out_train;
    logic [15:0] out_ratio;
    logic [5:0]  rank;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [7:0]  query;
    logic [15:0] best;
    logic [15:0] ratio;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_WRITE = 6'b000100,
    S_START = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// File: src/mdr_div.sv
// mdr_div: bit-serial Q0.16 ratio divider, one quotient bit per cycle
// depends on nothing but its ports
`timescale 1ns / 1ps
`default_nettype none
module mdr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] best,
  input  wire logic [15:0] second,
  output logic             running,
  output logic [15:0]      ratio
);

  logic [16:0] rem;
  logic [15:0] den;
  logic [15:0] quo;
  logic [4:0]  cnt;
  logic        sat;
  logic [16:0] rem_sh;
  logic        fits;

  // shift and trial subtract
  assign rem_sh = {rem[15:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= 5'd16;
    end else if (running) begin
      cnt     <= cnt - 5'd1;
      running <= cnt != 5'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, best};
      den <= second;
      quo <= '0;
      sat <= (second == 16'd0) || (second <= best);
    end else if (running) begin
      rem <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
      quo <= {quo[14:0], fits};
    end
  end

  assign ratio = sat ? 16'hFFFF : quo;

endmodule
`default_nettype wire

// File: src/mdr_mem.sv
// mdr_mem: entry store, one write and one registered read port
// depends on mdr_pkg
`timescale 1ns / 1ps
`default_nettype none
module mdr_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [mdr_pkg::ADDR_W-1:0] waddr,
  input  wire mdr_pkg::entry_t            wdata,
  input  wire logic                       re,
  input  wire logic [mdr_pkg::ADDR_W-1:0] raddr,
  output mdr_pkg::entry_t                 rdata
);

  mdr_pkg::entry_t mem [mdr_pkg::KEYPOINT_MAX];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/match_dedup_ratio_topk_core.sv
// match_dedup_ratio_topk_core: ratio-test match filter with dedup and top-k ranking
// depends on mdr_pkg, mdr_div, mdr_mem
// request: read, ratio divide, write back; busy meanwhile
// last request: then one selection pass per result (table scan
// at one entry per cycle through the read port), up to keep_count passes
// results are one-cycle strobes and cannot be stalled
// reset (rst, synchronous): valid map cleared at once, keep_count = 50
`timescale 1ns / 1ps
`default_nettype none
module match_dedup_ratio_topk_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire mdr_pkg::req_t request,
  input  wire logic          cfg_we,
  input  wire logic [6:0]    cfg_wdata,
  output logic               strobe,
  output mdr_pkg::res_t      result
);

  localparam int AW = mdr_pkg::ADDR_W;

  mdr_pkg::state_t state;
  mdr_pkg::req_t   req;
  logic [6:0]      keep_count;
  logic [mdr_pkg::KEYPOINT_MAX-1:0] entry_valid;
  logic [mdr_pkg::CNT_W-1:0] count;

  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  mdr_pkg::entry_t mem_wdata;
  mdr_pkg::entry_t mem_rdata;

  logic            div_start;
  logic            div_running;
  logic [15:0]     div_ratio;

  logic [AW-1:0]   scan_addr;
  logic            pipe_vld;
  logic [AW-1:0]   pipe_addr;
  logic            found;
  logic [AW-1:0]   sel_addr;
  logic [15:0]     sel_ratio;
  logic [7:0]      sel_query;
  logic [15:0]     last_ratio;
  logic [AW-1:0]   last_addr;
  logic            after_last;
  logic [6:0]      k;
  logic [6:0]      limit;
  logic [6:0]      n_out;
  logic            accept;
  logic            do_store;
  logic            take;

  assign busy   = state != mdr_pkg::S_IDLE;
  assign accept = start && !busy;

  // emitted count = min(keep_count, KEEP_MAX, stored entries)
  assign limit = (keep_count > mdr_pkg::KEEP_LIMIT) ? mdr_pkg::KEEP_LIMIT : keep_count;
  assign n_out = ({2'b00, limit} > count) ? 7'(count) : limit;

  // replace only on empty slot or strictly smaller distance
  assign do_store = !entry_valid[req.train_index[AW-1:0]] ||
                    (req.best_distance < mem_rdata.best);
  assign mem_we   = (state == mdr_pkg::S_WRITE) && do_store;
  assign mem_wdata = '{query: req.query_index, best: req.best_distance, ratio: div_ratio};
  assign mem_re    = accept || (state == mdr_pkg::S_SCAN);
  assign mem_raddr = accept ? request.train_index[AW-1:0] : scan_addr;
  assign div_start = accept;

  // only entries ranked after the last emitted one, by ratio then train index
  assign after_last = (k == 7'd0) || (mem_rdata.ratio > last_ratio) ||
                      ((mem_rdata.ratio == last_ratio) && (pipe_addr > last_addr));

  // candidate for the running minimum
  assign take = pipe_vld && entry_valid[pipe_addr] && after_last &&
                (!found || (mem_rdata.ratio < sel_ratio));

  mdr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .best    (request.best_distance),
    .second  (request.second_distance),
    .running (div_running),
    .ratio   (div_ratio)
  );

  mdr_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (req.train_index[AW-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= mdr_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
  end

  // running minimum over the scan
  always_ff @(posedge clk) begin
    if (take) begin
      sel_addr  <= pipe_addr;
      sel_ratio <= mem_rdata.ratio;
      sel_query <= mem_rdata.query;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == mdr_pkg::S_EMIT) begin
      result <= '{out_query: sel_query, out_train: 8'(sel_addr), out_ratio: sel_ratio,
                  rank: k[5:0], last_result: (k + 7'd1) == n_out};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mdr_pkg::S_IDLE;
      entry_valid <= '0;
      last_ratio  <= '0;
      last_addr   <= '0;
      count       <= '0;
      strobe      <= 1'b0;
      pipe_vld    <= 1'b0;
      found       <= 1'b0;
      scan_addr   <= '0;
      pipe_addr   <= '0;
      k           <= '0;
    end else begin
      strobe    <= 1'b0;
      pipe_vld  <= state == mdr_pkg::S_SCAN;
      pipe_addr <= scan_addr;
      if (take) begin
        found <= 1'b1;
      end
      case (state)
        mdr_pkg::S_IDLE: begin
          if (accept) begin
            state <= mdr_pkg::S_READ;
          end
        end
        mdr_pkg::S_READ: begin
          if (!div_running) begin
            state <= mdr_pkg::S_WRITE;
          end
        end
        mdr_pkg::S_WRITE: begin
          if (!entry_valid[req.train_index[AW-1:0]]) begin
            count <= count + 1'b1;
          end
          entry_valid[req.train_index[AW-1:0]] <= 1'b1;
          state <= req.last_match ? mdr_pkg::S_START : mdr_pkg::S_IDLE;
        end
        mdr_pkg::S_START: begin
          k         <= '0;
          found     <= 1'b0;
          scan_addr <= '0;
          if (n_out == 7'd0) begin
            entry_valid <= '0;
            count       <= '0;
            state       <= mdr_pkg::S_IDLE;
          end else begin
            state <= mdr_pkg::S_SCAN;
          end
        end
        mdr_pkg::S_SCAN: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == AW'(mdr_pkg::KEYPOINT_MAX - 1)) begin
            state <= mdr_pkg::S_EMIT;
          end
        end
        mdr_pkg::S_EMIT: begin
          // last scanned entry is folded in while pipe_vld is still set; wait for it
          if (!pipe_vld) begin
            strobe     <= 1'b1;
            last_ratio <= sel_ratio;
            last_addr  <= sel_addr;
            found      <= 1'b0;
            scan_addr  <= '0;
            k          <= k + 7'd1;
            if ((k + 7'd1) == n_out) begin
              entry_valid <= '0;
              count       <= '0;
              state       <= mdr_pkg::S_IDLE;
            end else begin
              state <= mdr_pkg::S_SCAN;
            end
          end
        end
        default: begin
          state <= mdr_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
